[rtl/core/iol_pkg.sv]
`timescale 1ns / 1ps
// Package for the indexed ordered list: sizes, opcodes, status codes and
// the payload and cell command structs. No dependencies.
package iol_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;

  localparam int OPC_W  = 3;
  localparam int POS_W  = 5;
  localparam int WORD_W = 32;
  localparam int STAT_W = 2;
  localparam int ECNT_W = 5;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CW    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [OPC_W-1:0] {
    OP_INSERT  = 3'd0,
    OP_APPEND  = 3'd1,
    OP_REMOVE  = 3'd2,
    OP_REMLAST = 3'd3,
    OP_READ    = 3'd4
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef struct packed {
    logic [OPC_W-1:0]  opcode;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] data_in;
  } in_item_t;

  typedef struct packed {
    status_e           status;
    logic [WORD_W-1:0] data_out;
    logic [ECNT_W-1:0] entry_count;
  } out_item_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic                  ins;
    logic                  rem;
    logic [CW-1:0]         pos;
    logic [CW-1:0]         tgt;
    logic [DATA_WIDTH-1:0] word;
  } cell_cmd_t;

endpackage

[rtl/core/iol_cell.sv]
`timescale 1ns / 1ps
// One storage cell of the list chain: holds, loads, takes its lower or
// upper neighbor's word. Depends on iol_pkg.
module iol_cell import iol_pkg::*; (
  input  logic                  clk_i,
  input  logic [CW-1:0]         idx_i,
  input  cell_cmd_t             cmd_i,
  input  logic [DATA_WIDTH-1:0] lower_i,
  input  logic [DATA_WIDTH-1:0] upper_i,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic [DATA_WIDTH-1:0] rd_o
);

  logic [DATA_WIDTH-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (cmd_i.ins) begin
      if (idx_i == cmd_i.pos) begin
        data_d = cmd_i.word;
      end else if (idx_i > cmd_i.pos) begin
        data_d = lower_i;
      end
    end else if (cmd_i.rem) begin
      if (idx_i >= cmd_i.pos) begin
        data_d = upper_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign rd_o   = (idx_i == cmd_i.tgt) ? data_q : '0;

endmodule

[rtl/core/iol_ctrl.sv]
`timescale 1ns / 1ps
// Control of the indexed ordered list: opcode decode, entry count, status
// and the output register. Depends on iol_pkg.
module iol_ctrl import iol_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_data_o,
  input  logic [DATA_WIDTH-1:0] rd_data_i,
  output cell_cmd_t             cmd_o
);

  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q;
  out_item_t        out_q;

  logic          accept;
  logic [CW-1:0] pos_w, cnt_w;
  logic          ins, rem, rd_en;
  status_e       status;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign pos_w      = CW'(in_data_i.position);
  assign cnt_w      = CW'(count_q);

  always_comb begin
    ins     = 1'b0;
    rem     = 1'b0;
    rd_en   = 1'b0;
    status  = ST_OK;
    count_d = count_q;
    cmd_o.pos = pos_w;
    cmd_o.tgt = pos_w;
    cmd_o.word = DATA_WIDTH'(in_data_i.data_in);
    case (in_data_i.opcode)
      OP_INSERT: begin
        if (pos_w > cnt_w) begin
          status = ST_BADPOS;
        end else if (count_q == CNT_W'(DEPTH)) begin
          status = ST_FULL;
        end else begin
          ins     = 1'b1;
          count_d = count_q + CNT_W'(1);
        end
      end
      OP_APPEND: begin
        cmd_o.pos = cnt_w;
        if (count_q == CNT_W'(DEPTH)) begin
          status = ST_FULL;
        end else begin
          ins     = 1'b1;
          count_d = count_q + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (count_q == '0) begin
          status = ST_EMPTY;
        end else if (pos_w >= cnt_w) begin
          status = ST_BADPOS;
        end else begin
          rem     = 1'b1;
          rd_en   = 1'b1;
          count_d = count_q - CNT_W'(1);
        end
      end
      OP_REMLAST: begin
        cmd_o.tgt = CW'(count_q - CNT_W'(1));
        if (count_q == '0) begin
          status = ST_EMPTY;
        end else begin
          rd_en   = 1'b1;
          count_d = count_q - CNT_W'(1);
        end
      end
      OP_READ: begin
        if (count_q == '0) begin
          status = ST_EMPTY;
        end else if (pos_w >= cnt_w) begin
          status = ST_BADPOS;
        end else begin
          rd_en = 1'b1;
        end
      end
      default: begin
        status = ST_BADPOS;
      end
    endcase
    cmd_o.ins = ins && accept;
    cmd_o.rem = rem && accept;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q.status      <= status;
      out_q.data_out    <= rd_en ? WORD_W'(rd_data_i) : '0;
      out_q.entry_count <= ECNT_W'(count_d);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_ins_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.ins |-> (count_q < CNT_W'(DEPTH)) && !cmd_o.rem)
    else $error("insert into full list or mixed command");

  a_rem_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rem |-> count_q != '0)
    else $error("remove from empty list");

  a_accept_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("transfer without result");

  a_read_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_data_i.opcode == OP_READ) |=> count_q == $past(count_q))
    else $error("read changed count");

endmodule

[rtl/core/indexed_ordered_list.sv]
`timescale 1ns / 1ps
// Top level of the indexed ordered list: a chain of word cells under one
// controller. Depends on iol_pkg, iol_cell and iol_ctrl.
//
// Usage:
//   Input channel in_valid_i / in_ready_o / in_data_i carries opcode,
//   position and data word. Output channel out_valid_o / out_ready_i /
//   out_data_o carries status, data word and the entry count after the
//   operation. Every input transfer yields exactly one result.
//   Latency: the result is valid the cycle after the input transfer.
//   Throughput: one item per cycle; every cell shifts, loads or holds in
//   the same cycle, so insert and remove cost the same as read.
//   The input is ready whenever the output register is empty or is being
//   taken in the same cycle; a stalled receiver holds the result and
//   blocks further input until it is taken.
//   Reset clears the entry count and the output valid; cell contents are
//   not cleared and are never read before being written.
module indexed_ordered_list import iol_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  cell_cmd_t             cmd;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DATA_WIDTH-1:0] cell_rd   [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data;

  iol_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .rd_data_i   (rd_data),
    .cmd_o       (cmd)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] lower, upper;
    if (i == 0) begin : g_lo
      assign lower = cell_data[i];
    end else begin : g_lo
      assign lower = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_hi
      assign upper = cell_data[i];
    end else begin : g_hi
      assign upper = cell_data[i+1];
    end
    iol_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (CW'(i)),
      .cmd_i   (cmd),
      .lower_i (lower),
      .upper_i (upper),
      .data_o  (cell_data[i]),
      .rd_o    (cell_rd[i])
    );
  end

  always_comb begin
    rd_data = '0;
    for (int k = 0; k < DEPTH; k++) begin
      rd_data = rd_data | cell_rd[k];
    end
  end

endmodule

[tb/iol_tb_pkg.sv]
`timescale 1ns / 1ps
// Scoreboard for the indexed ordered list testbench: a list predictor and the
// queue of expected results it feeds. Depends on iol_pkg.
package iol_tb_pkg;
  import iol_pkg::*;

  class list_scoreboard;
    logic [DATA_WIDTH-1:0] cells [DEPTH];
    int                    list_len;
    out_item_t             pending_results [$];
    int unsigned           mismatches;
    int unsigned           checked;
    int unsigned           op_seen [1 << OPC_W];
    int unsigned           status_seen [1 << STAT_W];

    function new();
      list_len   = 0;
      mismatches = 0;
      checked    = 0;
    endfunction

    task flag_mismatch(string msg);
      mismatches++;
      $display("[%0t] MISMATCH #%0d: %s", $realtime, mismatches, msg);
    endtask

    function int outstanding();
      return pending_results.size();
    endfunction

    // Applies one operation to the predicted list, returns the expected result.
    function out_item_t apply_op(in_item_t req);
      out_item_t             res;
      int                    pos;
      logic [DATA_WIDTH-1:0] word;
      pos          = int'(req.position);
      word         = req.data_in[DATA_WIDTH-1:0];
      res.status   = ST_OK;
      res.data_out = '0;
      case (req.opcode)
        OP_INSERT: begin
          if (pos > list_len) begin
            res.status = ST_BADPOS;
          end else if (list_len >= DEPTH) begin
            res.status = ST_FULL;
          end else begin
            for (int i = list_len; i > pos; i--) cells[i] = cells[i-1];
            cells[pos] = word;
            list_len++;
          end
        end
        OP_APPEND: begin
          if (list_len >= DEPTH) begin
            res.status = ST_FULL;
          end else begin
            cells[list_len] = word;
            list_len++;
          end
        end
        OP_REMOVE: begin
          if (list_len == 0) begin
            res.status = ST_EMPTY;
          end else if (pos >= list_len) begin
            res.status = ST_BADPOS;
          end else begin
            res.data_out = WORD_W'(cells[pos]);
            for (int i = pos; i + 1 < list_len; i++) cells[i] = cells[i+1];
            list_len--;
          end
        end
        OP_REMLAST: begin
          if (list_len == 0) begin
            res.status = ST_EMPTY;
          end else begin
            list_len--;
            res.data_out = WORD_W'(cells[list_len]);
          end
        end
        OP_READ: begin
          if (list_len == 0) begin
            res.status = ST_EMPTY;
          end else if (pos >= list_len) begin
            res.status = ST_BADPOS;
          end else begin
            res.data_out = WORD_W'(cells[pos]);
          end
        end
        default: begin
          res.status = ST_BADPOS;
        end
      endcase
      res.entry_count = ECNT_W'(list_len);
      return res;
    endfunction

    function void take_request(in_item_t req);
      out_item_t res;
      op_seen[req.opcode]++;
      res = apply_op(req);
      status_seen[res.status]++;
      pending_results.push_back(res);
    endfunction

    task check_response(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result with nothing outstanding: %s %h %0d",
                                got.status.name(), got.data_out, got.entry_count));
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (got.status !== want.status)
        flag_mismatch($sformatf("result %0d status %s, expected %s", checked,
                                got.status.name(), want.status.name()));
      if (got.data_out !== want.data_out)
        flag_mismatch($sformatf("result %0d data %h, expected %h", checked,
                                got.data_out, want.data_out));
      if (got.entry_count !== want.entry_count)
        flag_mismatch($sformatf("result %0d count %0d, expected %0d", checked,
                                got.entry_count, want.entry_count));
    endtask

    task close_out();
      if (pending_results.size() != 0)
        flag_mismatch($sformatf("%0d expected results never arrived",
                                pending_results.size()));
    endtask
  endclass

endpackage

[tb/testbench.sv]
`timescale 1ns / 1ps
// Top-level testbench for indexed_ordered_list: directed and random list
// operations with random stalls on both channels. Depends on iol_pkg, iol_tb_pkg.
module testbench;
  import iol_pkg::*;
  import iol_tb_pkg::*;

  localparam logic [OPC_W-1:0] OP_FIRST_UNUSED = 3'd5;
  localparam logic [OPC_W-1:0] OP_LAST_UNUSED  = 3'd7;
  localparam int               POS_MAX         = (1 << POS_W) - 1;
  localparam int               RANDOM_ITEMS    = 800;

  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_BALANCED} mix_e;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  list_scoreboard sb;
  bit             calm;

  indexed_ordered_list dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("Timeout: results still outstanding");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.take_request(in_data);
      if (out_valid && out_ready) sb.check_response(out_data);
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Called at a falling edge; returns at a falling edge after the transfer, once any random gap has passed.
  task automatic send_item(in_item_t req);
    int gap;
    in_data  <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic push_op(logic [OPC_W-1:0] opc, int pos, logic [WORD_W-1:0] word);
    in_item_t req;
    req.opcode   = opc;
    req.position = POS_W'(pos);
    req.data_in  = word;
    send_item(req);
  endtask

  task automatic drain_wait();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  function automatic in_item_t make_random_op(mix_e mix);
    in_item_t req;
    int       len;
    int       r;
    int       t_ins, t_app, t_rem, t_last;
    len = sb.list_len;
    case (mix)
      MIX_GROW:   begin t_ins = 35; t_app = 65; t_rem = 75; t_last = 85; end
      MIX_SHRINK: begin t_ins = 10; t_app = 20; t_rem = 55; t_last = 80; end
      default:    begin t_ins = 20; t_app = 40; t_rem = 60; t_last = 75; end
    endcase
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 3)
      req.opcode = OPC_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
    else if (r < t_ins)            req.opcode = OP_INSERT;
    else if (r < t_app)            req.opcode = OP_APPEND;
    else if (r < t_rem)            req.opcode = OP_REMOVE;
    else if (r < t_last)           req.opcode = OP_REMLAST;
    else                           req.opcode = OP_READ;
    if ($urandom_range(0, 99) < 15)   req.position = POS_W'($urandom_range(0, POS_MAX));
    else if (req.opcode == OP_INSERT) req.position = POS_W'($urandom_range(0, len));
    else if (len > 0)                 req.position = POS_W'($urandom_range(0, len - 1));
    else                              req.position = POS_W'($urandom_range(0, POS_MAX));
    r = $urandom_range(0, 19);
    if (r == 0)      req.data_in = '0;
    else if (r == 1) req.data_in = '1;
    else             req.data_in = $urandom;
    return req;
  endfunction

  initial begin
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      int stall;
      @(negedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(0, 7)) @(negedge clk);
    end
  end

  initial begin
    int          sent;
    int          block_len;
    int          blocks;
    int          waited;
    int unsigned unused_ops;
    mix_e        mix;

    sb       = new();
    calm     = 1'b0;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty list and unused opcodes
    push_op(OP_REMOVE, 0, '0);
    push_op(OP_REMLAST, 0, '0);
    push_op(OP_READ, 0, '0);
    push_op(OP_INSERT, 1, $urandom);
    push_op(OP_LAST_UNUSED, POS_MAX, '1);
    push_op(OP_FIRST_UNUSED, 0, $urandom);
    // fill to capacity: append, insert at front, end and middle
    push_op(OP_APPEND, 0, '0);
    push_op(OP_APPEND, 0, '1);
    push_op(OP_INSERT, 0, $urandom);
    push_op(OP_INSERT, 3, $urandom);
    push_op(OP_INSERT, 2, $urandom);
    while (sb.list_len < DEPTH) begin
      if (sb.list_len % 2 == 0) push_op(OP_APPEND, 0, $urandom);
      else                      push_op(OP_INSERT, $urandom_range(0, sb.list_len), $urandom);
    end
    // full list, bad position checked before full
    push_op(OP_APPEND, 0, $urandom);
    push_op(OP_INSERT, DEPTH, $urandom);
    push_op(OP_INSERT, POS_MAX, $urandom);
    push_op(OP_READ, DEPTH - 1, '0);
    push_op(OP_READ, DEPTH, '0);
    push_op(OP_REMOVE, 0, '0);
    push_op(OP_REMLAST, 0, '0);
    drain_wait();

    sent   = 0;
    blocks = 0;
    while (sent < RANDOM_ITEMS) begin
      mix       = mix_e'($urandom_range(0, 2));
      calm      = ($urandom_range(0, 3) == 0);
      block_len = $urandom_range(20, 60);
      repeat (block_len) begin
        send_item(make_random_op(mix));
        sent++;
      end
      blocks++;
      if (blocks % 4 == 0) drain_wait();
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    waited = 0;
    while (sb.outstanding() != 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    repeat (4) @(negedge clk);
    sb.close_out();

    unused_ops = 0;
    for (int op = OP_FIRST_UNUSED; op <= OP_LAST_UNUSED; op++) unused_ops += sb.op_seen[op];
    $display("Ran %0d operations: %0d insert, %0d append, %0d remove,",
             sb.checked + sb.outstanding(), sb.op_seen[OP_INSERT], sb.op_seen[OP_APPEND],
             sb.op_seen[OP_REMOVE]);
    $display("  %0d remove-last, %0d read, %0d unused",
             sb.op_seen[OP_REMLAST], sb.op_seen[OP_READ], unused_ops);
    $display("Checked %0d results: %0d ok, %0d bad position, %0d empty, %0d full",
             sb.checked, sb.status_seen[ST_OK], sb.status_seen[ST_BADPOS],
             sb.status_seen[ST_EMPTY], sb.status_seen[ST_FULL]);
    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/iol_pkg.sv
rtl/core/iol_cell.sv
rtl/core/iol_ctrl.sv
rtl/core/indexed_ordered_list.sv
tb/iol_tb_pkg.sv
tb/testbench.sv
